// File: hdl/crc24sb_pkg.sv
// Shared types, constants and CRC-24 helper functions for the Mode S
// syndrome and bit error locator. No dependencies.
package crc24sb_pkg;

   localparam logic [23:0] CRC_POLY = 24'hFFF409;

   // Message lengths in bytes that the locator accepts (56 and 112 bits).
   localparam logic [4:0] SHORT_MSG_BYTES = 5'd7;
   localparam logic [4:0] LONG_MSG_BYTES  = 5'd14;
   localparam logic [4:0] COUNT_MAX       = 5'd31;
   // Number of parity bytes held back from the CRC.
   localparam logic [4:0] PARITY_BYTES    = 5'd3;

   // Highest exponent searched, that is message bits minus one.
   localparam logic [6:0] SHORT_LAST_EXP = 7'd55;
   localparam logic [6:0] LONG_LAST_EXP  = 7'd111;

   typedef enum logic [1:0] {
      LEN_SHORT = 2'd0,
      LEN_LONG  = 2'd1,
      LEN_BAD   = 2'd2
   } len_type;

   typedef enum logic [1:0] {
      STATUS_FOUND   = 2'd0,
      STATUS_NOMATCH = 2'd1,
      STATUS_BADLEN  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_SEARCH = 2'd1,
      ST_DONE   = 2'd2
   } state_type;

   // One finished message handed from the front end to the locator.
   typedef struct packed {
      logic [23:0] syndrome;
      len_type     len;
   } job_type;

   // Multiply a residue by x modulo the generator.
   function automatic logic [23:0] times_x(input logic [23:0] r);
      logic [23:0] shifted;
      shifted = {r[22:0], 1'b0};
      return r[23] ? (shifted ^ CRC_POLY) : shifted;
   endfunction

   // Advance the CRC by one byte, most significant bit first.
   function automatic logic [23:0] crc_byte(input logic [23:0] crc, input logic [7:0] data);
      logic [23:0] r;
      r = crc ^ {data, 16'd0};
      for (int k = 0; k < 8; k++) begin
         r = times_x(r);
      end
      return r;
   endfunction

endpackage

// File: hdl/crc24sb_front.sv
// Front end: takes message bytes, runs the CRC-24 over all but the final
// three bytes and forms the syndrome on the last byte. Uses crc24sb_pkg.
module crc24sb_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_data_byte,
   input  logic                 req_last,
   input  logic [23:0]          crc_start,
   output logic                 push_valid,
   input  logic                 push_ready,
   output crc24sb_pkg::job_type push_job
);

   logic [23:0] crc_ff, crc_in;
   logic [23:0] pd_ff, pd_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [23:0] cur_crc, cur_pd, new_crc, new_pd;
   logic [4:0]  new_cnt;
   logic        accept;

   // A byte is only taken when the queue could hold a finished message.
   assign req_ready  = push_ready;
   assign accept     = req_valid && req_ready;
   assign push_valid = req_valid && req_last;

   always_comb begin
      cur_crc = (cnt_ff == 5'd0) ? crc_start : crc_ff;
      cur_pd  = (cnt_ff == 5'd0) ? 24'd0 : pd_ff;
      new_crc = (cnt_ff >= crc24sb_pkg::PARITY_BYTES)
              ? crc24sb_pkg::crc_byte(cur_crc, cur_pd[23:16]) : cur_crc;
      new_pd  = {cur_pd[15:0], req_data_byte};
      new_cnt = (cnt_ff == crc24sb_pkg::COUNT_MAX) ? cnt_ff : cnt_ff + 5'd1;

      push_job.syndrome = (new_cnt < crc24sb_pkg::PARITY_BYTES) ? 24'd0 : (new_crc ^ new_pd);
      priority if (new_cnt == crc24sb_pkg::SHORT_MSG_BYTES) begin
         push_job.len = crc24sb_pkg::LEN_SHORT;
      end else if (new_cnt == crc24sb_pkg::LONG_MSG_BYTES) begin
         push_job.len = crc24sb_pkg::LEN_LONG;
      end else begin
         push_job.len = crc24sb_pkg::LEN_BAD;
      end

      crc_in = crc_ff;
      pd_in  = pd_ff;
      cnt_in = cnt_ff;
      if (accept) begin
         crc_in = new_crc;
         pd_in  = new_pd;
         cnt_in = req_last ? 5'd0 : new_cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 5'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      crc_ff <= crc_in;
      pd_ff  <= pd_in;
   end

endmodule

// File: hdl/crc24sb_queue.sv
// Short queue of finished messages between the front end and the locator.
// Uses crc24sb_pkg for the entry type.
module crc24sb_queue #(
   parameter int DEPTH = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  crc24sb_pkg::job_type push_job,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output crc24sb_pkg::job_type pop_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   crc24sb_pkg::job_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign push_ready = (cnt_ff != FULL_CNT);
   assign pop_valid  = (cnt_ff != '0);
   assign pop_job    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= FULL_CNT)
      else $error("queue count beyond depth");

   a_cnt_push: assert property (@(posedge clock) disable iff (reset)
      do_push && !do_pop |=> cnt_ff != '0)
      else $error("queue empty after a push");

   a_ptrs_empty: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == '0 |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers differ while empty");

endmodule

// File: hdl/crc24sb_locate.sv
// Back end: walks x^e mod G over every exponent of the message length and
// reports the lowest bit index whose flip gives the syndrome. Uses crc24sb_pkg.
module crc24sb_locate (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  crc24sb_pkg::job_type pop_job,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [23:0]          rsp_syndrome,
   output logic [6:0]           rsp_error_bit,
   output logic [1:0]           rsp_locate_status
);

   crc24sb_pkg::state_type state_ff, state_in;
   logic [23:0] syn_ff, syn_in;
   logic [23:0] res_ff, res_in;
   logic [6:0]  exp_ff, exp_in;
   logic [6:0]  last_exp_ff, last_exp_in;
   logic [6:0]  bit_ff, bit_in;
   logic        found_ff, found_in;
   logic        bad_ff, bad_in;
   logic        load;
   crc24sb_pkg::status_type status;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         crc24sb_pkg::ST_IDLE: begin
            if (pop_valid) begin
               state_in = (pop_job.len == crc24sb_pkg::LEN_BAD)
                        ? crc24sb_pkg::ST_DONE : crc24sb_pkg::ST_SEARCH;
            end
         end
         crc24sb_pkg::ST_SEARCH: begin
            if (exp_ff == last_exp_ff) begin
               state_in = crc24sb_pkg::ST_DONE;
            end
         end
         crc24sb_pkg::ST_DONE: begin
            if (rsp_ready) begin
               state_in = crc24sb_pkg::ST_IDLE;
            end
         end
         default: state_in = crc24sb_pkg::ST_IDLE;
      endcase
   end

   // Outputs of the state machine.
   always_comb begin
      pop_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         crc24sb_pkg::ST_IDLE:   pop_ready = 1'b1;
         crc24sb_pkg::ST_SEARCH: ;
         crc24sb_pkg::ST_DONE:   rsp_valid = 1'b1;
         default: ;
      endcase
   end

   assign load = pop_valid && pop_ready;

   // Search datapath. The last match seen is the lowest bit index.
   always_comb begin
      syn_in      = syn_ff;
      res_in      = res_ff;
      exp_in      = exp_ff;
      last_exp_in = last_exp_ff;
      bit_in      = bit_ff;
      found_in    = found_ff;
      bad_in      = bad_ff;
      if (load) begin
         syn_in      = pop_job.syndrome;
         res_in      = 24'd1;
         exp_in      = 7'd0;
         last_exp_in = (pop_job.len == crc24sb_pkg::LEN_LONG)
                     ? crc24sb_pkg::LONG_LAST_EXP : crc24sb_pkg::SHORT_LAST_EXP;
         bit_in      = 7'd0;
         found_in    = 1'b0;
         bad_in      = (pop_job.len == crc24sb_pkg::LEN_BAD);
      end else if (state_ff == crc24sb_pkg::ST_SEARCH) begin
         if (res_ff == syn_ff) begin
            bit_in   = last_exp_ff - exp_ff;
            found_in = 1'b1;
         end
         res_in = crc24sb_pkg::times_x(res_ff);
         exp_in = exp_ff + 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= crc24sb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      syn_ff      <= syn_in;
      res_ff      <= res_in;
      exp_ff      <= exp_in;
      last_exp_ff <= last_exp_in;
      bit_ff      <= bit_in;
      found_ff    <= found_in;
      bad_ff      <= bad_in;
   end

   always_comb begin
      priority if (bad_ff) begin
         status = crc24sb_pkg::STATUS_BADLEN;
      end else if (found_ff) begin
         status = crc24sb_pkg::STATUS_FOUND;
      end else begin
         status = crc24sb_pkg::STATUS_NOMATCH;
      end
   end

   assign rsp_syndrome      = syn_ff;
   assign rsp_error_bit     = bit_ff;
   assign rsp_locate_status = status;

   a_exp_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == crc24sb_pkg::ST_SEARCH |-> exp_ff <= last_exp_ff)
      else $error("search exponent ran past the message length");

   a_found_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == crc24sb_pkg::STATUS_FOUND |-> syn_ff != 24'd0)
      else $error("zero syndrome reported as a single-bit error");

   a_bit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == crc24sb_pkg::STATUS_FOUND |-> bit_ff <= last_exp_ff)
      else $error("error bit beyond message length");

   a_bad_bit_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && bad_ff |-> bit_ff == 7'd0)
      else $error("error bit set on invalid length");

endmodule

// File: hdl/crc24_syndrome_bit_error_locator_core.sv
// Flow: the last byte of a message enters the queue at its acceptance edge; the
// locator loads it once idle and walks the exponents (one exponent per cycle) of a
// short or long message (none for an invalid length) before the result is shown.
// Throughput: one byte per cycle while the queue has room; the locator takes a new
// message only after the result of the one before has been taken.
// Reset (synchronous): control state clears, crc_start returns to zero; no clearing pass.
//
// Top level of the Mode S CRC-24 syndrome and single-bit error locator.
// Uses crc24sb_pkg, crc24sb_front, crc24sb_queue and crc24sb_locate.
module crc24_syndrome_bit_error_locator_core #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   // Configuration: initial CRC value for each message.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [23:0] csr_crc_start,
   // Message bytes.
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last,
   // One result transaction per message.
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [23:0] rsp_syndrome,
   output logic [6:0]  rsp_error_bit,
   output logic [1:0]  rsp_locate_status
);

   logic [23:0] crc_start_ff, crc_start_in;

   logic                 push_valid, push_ready;
   crc24sb_pkg::job_type push_job;
   logic                 pop_valid, pop_ready;
   crc24sb_pkg::job_type pop_job;

   // The configuration register is always writable. A write takes effect at the
   // first byte of the next message, since the front end samples it only there.
   assign csr_ready    = 1'b1;
   assign crc_start_in = (csr_valid && csr_ready) ? csr_crc_start : crc_start_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_start_ff <= 24'd0;
      end else begin
         crc_start_ff <= crc_start_in;
      end
   end

   // The front end runs the CRC at one byte per cycle while the queue has room and
   // queues each message, syndrome plus length class, in the cycle of its last byte.
   crc24sb_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_last      (req_last),
      .crc_start     (crc_start_ff),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_job      (push_job)
   );

   // The queue lets the front end keep taking bytes of the next message while the
   // locator is still searching or its result transaction is waiting to be taken.
   crc24sb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   // The locator compares the syndrome against x^e mod G for every exponent of
   // a message of valid length and holds the result registered until it is taken.
   crc24sb_locate u_locate (
      .clock             (clock),
      .reset             (reset),
      .pop_valid         (pop_valid),
      .pop_ready         (pop_ready),
      .pop_job           (pop_job),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_syndrome      (rsp_syndrome),
      .rsp_error_bit     (rsp_error_bit),
      .rsp_locate_status (rsp_locate_status)
   );

endmodule

// File: sim/crc24_syndrome_bit_error_locator_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the Mode S CRC-24 syndrome and single-bit error locator.
// Depends on crc24sb_pkg and crc24_syndrome_bit_error_locator_core; reads no files.
module crc24_syndrome_bit_error_locator_core_test;

   localparam logic [23:0] GEN_POLY = 24'hFFF409;
   localparam int SHORT_BITS = 56;
   localparam int LONG_BITS = 112;
   localparam int RANDOM_BYTES = 1750;
   localparam int PHASES = 3;
   // This covers the tail of the locator's search for the last message.
   localparam int TAIL_CYCLES = 130;
   localparam int DRAIN_LIMIT = 50000;
   localparam int PRINT_LIMIT = 40;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
   } msg_byte_type;

   typedef struct packed {
      logic [23:0]             syndrome;
      logic [6:0]              error_bit;
      crc24sb_pkg::status_type status;
   } locate_result_type;

   // Shapes of generated messages. All but noise carry correct parity
   // before the damage is applied.
   typedef enum int {
      MSG_CLEAN,
      MSG_ONE_FLIP,
      MSG_TWO_FLIP,
      MSG_ADDRESS,
      MSG_NOISE
   } msg_kind_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [23:0] csr_crc_start = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = '0;
   logic        req_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [23:0] rsp_syndrome;
   logic [6:0]  rsp_error_bit;
   logic [1:0]  rsp_locate_status;

   // Bytes waiting to be offered, and results predicted but not yet seen.
   msg_byte_type      outgoing_bytes[$];
   locate_result_type awaited_results[$];

   // Shadow of the block: the programmed start value and the per-message state.
   logic [23:0] start_value = '0;
   logic [23:0] running_crc = '0;
   logic [23:0] parity_window = '0;
   logic [4:0]  bytes_seen = '0;

   // Syndrome of flipping bit i of a short or long message, indexed by i.
   logic [23:0] flip_short [SHORT_BITS];
   logic [23:0] flip_long [LONG_BITS];

   int  mismatches = 0;
   int  bytes_accepted = 0;
   int  results_checked = 0;
   int  found_count = 0;
   bit  quiet = 1'b0;
   bit  byte_taken = 1'b0;

   crc24_syndrome_bit_error_locator_core dut (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_crc_start     (csr_crc_start),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_last          (req_last),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_syndrome      (rsp_syndrome),
      .rsp_error_bit     (rsp_error_bit),
      .rsp_locate_status (rsp_locate_status)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Bit-serial CRC-24, most significant bit first: each data bit is folded
   // into the feedback term rather than pre-XORed into the register.
   function automatic logic [23:0] crc_update(input logic [23:0] crc, input logic [7:0] b);
      logic [23:0] r;
      logic        fb;
      r = crc;
      for (int k = 7; k >= 0; k--) begin
         fb = r[23] ^ b[k];
         r = {r[22:0], 1'b0} ^ (fb ? GEN_POLY : 24'h0);
      end
      return r;
   endfunction

   // Advance the shadow state by one accepted byte. The final three bytes sit
   // in the parity window; a byte only enters the CRC once three newer bytes
   // have pushed it out. On the last byte the expected result is queued.
   function automatic void absorb_byte(input logic [7:0] b, input logic is_last);
      locate_result_type res;
      int nbits;
      if (bytes_seen == 5'd0) begin
         running_crc = start_value;
         parity_window = '0;
      end
      if (bytes_seen >= 5'd3) begin
         running_crc = crc_update(running_crc, parity_window[23:16]);
      end
      parity_window = {parity_window[15:0], b};
      // The length counter saturates, so very long messages read as 31 bytes.
      if (bytes_seen != 5'd31) begin
         bytes_seen = bytes_seen + 5'd1;
      end
      if (is_last) begin
         res.error_bit = '0;
         res.status = crc24sb_pkg::STATUS_BADLEN;
         if (bytes_seen < 5'd3) begin
            // Too short to hold the parity field at all.
            res.syndrome = '0;
         end else begin
            res.syndrome = running_crc ^ parity_window;
            nbits = int'(bytes_seen) * 8;
            if (nbits == SHORT_BITS || nbits == LONG_BITS) begin
               res.status = crc24sb_pkg::STATUS_NOMATCH;
               // Walk from the top index down so that the lowest match wins.
               for (int i = nbits - 1; i >= 0; i--) begin
                  if ((nbits == SHORT_BITS ? flip_short[i] : flip_long[i]) == res.syndrome) begin
                     res.status = crc24sb_pkg::STATUS_FOUND;
                     res.error_bit = 7'(i);
                  end
               end
            end
         end
         awaited_results.push_back(res);
         bytes_seen = '0;
      end
   endfunction

   task automatic flag_mismatch(input string what, input logic [23:0] wanted,
                                input logic [23:0] got);
      if (mismatches < PRINT_LIMIT) begin
         $display("%0t ns: mismatch in %s: expected %0h, got %0h", $time, what, wanted, got);
      end
      mismatches++;
   endtask

   // Mostly a random bit, but the first and last bits of the message come up
   // often so that both ends of the error_bit range are hit.
   function automatic int choose_bit(input int nbits);
      int roll;
      roll = $urandom_range(7);
      if (roll == 0) begin
         return 0;
      end else if (roll == 1) begin
         return nbits - 1;
      end
      return $urandom_range(nbits - 1);
   endfunction

   // Build one message with random content and queue its bytes. Messages other
   // than noise get parity matching the current start value, then the damage
   // that the kind calls for. A flip_at of zero or more forces the flipped bit.
   task automatic queue_message(input int nbytes, input msg_kind_type kind, input int flip_at);
      logic [7:0]  body [$];
      logic [23:0] crc;
      logic [23:0] tag;
      int          nbits;
      int          pos;
      nbits = nbytes * 8;
      for (int k = 0; k < nbytes; k++) begin
         body.push_back(8'($urandom));
      end
      if (kind != MSG_NOISE && nbytes >= 3) begin
         crc = start_value;
         for (int k = 0; k < nbytes - 3; k++) begin
            crc = crc_update(crc, body[k]);
         end
         body[nbytes - 3] = crc[23:16];
         body[nbytes - 2] = crc[15:8];
         body[nbytes - 1] = crc[7:0];
         case (kind)
            MSG_ONE_FLIP, MSG_TWO_FLIP: begin
               pos = (flip_at >= 0) ? flip_at : choose_bit(nbits);
               body[pos / 8] ^= 8'h80 >> (pos % 8);
               if (kind == MSG_TWO_FLIP) begin
                  pos = choose_bit(nbits);
                  body[pos / 8] ^= 8'h80 >> (pos % 8);
               end
            end
            MSG_ADDRESS: begin
               // Parity overlaid with an address, as short replies carry it.
               tag = 24'($urandom_range(24'hFFFFFF, 1));
               body[nbytes - 3] ^= tag[23:16];
               body[nbytes - 2] ^= tag[15:8];
               body[nbytes - 1] ^= tag[7:0];
            end
            default: begin
            end
         endcase
      end
      for (int k = 0; k < nbytes; k++) begin
         outgoing_bytes.push_back('{data_byte: body[k], last: (k == nbytes - 1)});
      end
   endtask

   // Wait until every queued byte has gone in and every predicted result has
   // come out, then let the block idle before touching it.
   task automatic wait_for_drain();
      int waited;
      waited = 0;
      while ((outgoing_bytes.size() != 0 || req_valid || awaited_results.size() != 0)
             && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (4) @(negedge clock);
   endtask

   // Register write transaction. It is only issued while the block is idle,
   // so the shadow start value can follow it at the accepting edge.
   task automatic load_crc_start(input logic [23:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_crc_start <= value;
      do @(posedge clock); while (!csr_ready);
      start_value = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Byte driver. A new byte is presented at the falling edge only once the
   // previous one has been taken, so valid and payload hold steady until then.
   always @(negedge clock) begin
      msg_byte_type next_byte;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || byte_taken) begin
         byte_taken = 1'b0;
         if (outgoing_bytes.size() != 0 && (quiet || $urandom_range(99) >= 15)) begin
            next_byte = outgoing_bytes.pop_front();
            req_valid <= 1'b1;
            req_data_byte <= next_byte.data_byte;
            req_last <= next_byte.last;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Each accepted byte transaction feeds the shadow state at the same edge.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         byte_taken = 1'b1;
         bytes_accepted++;
         absorb_byte(req_data_byte, req_last);
      end
   end

   // Result side: random back-pressure, except in the quiet stretch.
   always @(negedge clock) begin
      rsp_ready <= reset ? 1'b0 : (quiet || $urandom_range(99) >= 15);
   end

   // Each accepted result transaction is compared with the oldest prediction.
   always @(posedge clock) begin
      locate_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_results.size() == 0) begin
            flag_mismatch("result with no message pending", '0, rsp_syndrome);
         end else begin
            want = awaited_results.pop_front();
            results_checked++;
            if (want.status == crc24sb_pkg::STATUS_FOUND) begin
               found_count++;
            end
            if (rsp_syndrome !== want.syndrome) begin
               flag_mismatch("syndrome", want.syndrome, rsp_syndrome);
            end
            if (rsp_error_bit !== want.error_bit) begin
               flag_mismatch("error_bit", 24'(want.error_bit), 24'(rsp_error_bit));
            end
            if (rsp_locate_status !== want.status) begin
               flag_mismatch("locate_status", 24'(want.status), 24'(rsp_locate_status));
            end
         end
      end
   end

   initial begin
      logic [23:0]  phase_start [PHASES];
      logic [23:0]  r;
      int           queued;
      int           roll;
      int           len;
      msg_kind_type kind;

      // Single-bit syndromes: flipping bit i of an n-bit message adds
      // x^(n-1-i) mod G, so walk the powers of x upward.
      r = 24'h1;
      for (int e = 0; e < LONG_BITS; e++) begin
         if (e < SHORT_BITS) begin
            flip_short[SHORT_BITS - 1 - e] = r;
         end
         flip_long[LONG_BITS - 1 - e] = r;
         r = r[23] ? ({r[22:0], 1'b0} ^ GEN_POLY) : {r[22:0], 1'b0};
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part with a zero start value: one- and two-byte messages
      // (too short for parity), a bare three-byte parity field, a clean short
      // message and a short message with its first bit flipped.
      load_crc_start(24'h000000);
      outgoing_bytes.push_back('{data_byte: 8'hFF, last: 1'b1});
      outgoing_bytes.push_back('{data_byte: 8'h00, last: 1'b0});
      outgoing_bytes.push_back('{data_byte: 8'hFF, last: 1'b1});
      outgoing_bytes.push_back('{data_byte: 8'hA5, last: 1'b0});
      outgoing_bytes.push_back('{data_byte: 8'h5A, last: 1'b0});
      outgoing_bytes.push_back('{data_byte: 8'hC3, last: 1'b1});
      queue_message(7, MSG_CLEAN, -1);
      queue_message(7, MSG_ONE_FLIP, 0);

      // Random part in phases, each under its own start value. The middle
      // phase runs with no idling on either side.
      phase_start[0] = 24'hFFFFFF;
      phase_start[1] = 24'($urandom);
      phase_start[2] = 24'($urandom);
      for (int p = 0; p < PHASES; p++) begin
         wait_for_drain();
         load_crc_start(phase_start[p]);
         quiet = (p == 1);
         queued = 0;
         if (p == 0) begin
            // Error in the very last bit of a long message.
            queue_message(14, MSG_ONE_FLIP, LONG_BITS - 1);
            queued += 14;
         end
         while (queued < RANDOM_BYTES / PHASES) begin
            roll = $urandom_range(99);
            if (roll < 20) begin
               kind = MSG_CLEAN;
            end else if (roll < 50) begin
               kind = MSG_ONE_FLIP;
            end else if (roll < 60) begin
               kind = MSG_TWO_FLIP;
            end else if (roll < 70) begin
               kind = MSG_ADDRESS;
            end else begin
               kind = MSG_NOISE;
            end
            if (kind == MSG_NOISE) begin
               // Now and then long enough to saturate the byte counter.
               len = ($urandom_range(9) == 0) ? $urandom_range(40, 29) : $urandom_range(16, 1);
            end else begin
               len = ($urandom_range(9) == 0) ? $urandom_range(20, 3)
                                              : ($urandom_range(1) ? 14 : 7);
            end
            queue_message(len, kind, -1);
            queued += len;
         end
      end
      quiet = 1'b0;

      wait_for_drain();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (awaited_results.size() != 0) begin
         flag_mismatch("results never delivered", '0, 24'(awaited_results.size()));
      end

      $display("Sent %0d bytes under %0d start values; checked %0d results, %0d located errors.",
               bytes_accepted, PHASES + 1, results_checked, found_count);
      $display("Mismatches: %0d", mismatches);
      if (mismatches == 0) begin
         $display("crc24_syndrome_bit_error_locator_core_test: PASS");
      end else begin
         $display("crc24_syndrome_bit_error_locator_core_test: FAIL");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("crc24_syndrome_bit_error_locator_core_test: FAIL");
      $finish;
   end

endmodule

// File: crc24_syndrome_bit_error_locator_core.f
hdl/crc24sb_pkg.sv
hdl/crc24sb_front.sv
hdl/crc24sb_queue.sv
hdl/crc24sb_locate.sv
hdl/crc24_syndrome_bit_error_locator_core.sv
sim/crc24_syndrome_bit_error_locator_core_test.sv
